// File: design/triac_phase_dimmer_with_thermal_trip_assert.svh
// Assertion macros for the checker file tpd_checker.
`ifndef TRIAC_PHASE_DIMMER_WITH_THERMAL_TRIP_ASSERT_SVH
`define TRIAC_PHASE_DIMMER_WITH_THERMAL_TRIP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("tpd check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("tpd check failed");

`endif

// File: design/tpd_pkg.sv
package tpd_pkg;

    localparam int PHASE_BITS = 8;
    localparam int ADDR_BITS  = 5;

    localparam logic [PHASE_BITS-1:0] PHASE_MAX = '1;

    typedef enum logic [1:0] {
        OP_ZERO_CROSS   = 2'd0,
        OP_PHASE_TICK   = 2'd1,
        OP_CONTROL_TICK = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        REG_BRIGHT_HIGH      = 3'd0,
        REG_BRIGHT_LOW       = 3'd1,
        REG_TEMP_CHECK_LEVEL = 3'd2,
        REG_TEMP_TRIP_LEVEL  = 3'd3,
        REG_TRIP_COUNT       = 3'd4,
        REG_CHECK_LIMIT      = 3'd5,
        REG_AC_TIMEOUT       = 3'd6,
        REG_SEND_GAP         = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [6:0] bright_high;
        logic [6:0] bright_low;
        logic [9:0] temp_check_level;
        logic [9:0] temp_trip_level;
        logic [4:0] trip_count;
        logic [5:0] check_limit;
        logic [4:0] ac_timeout;
        logic [8:0] send_gap;
    } t_cfg;

    typedef struct packed {
        logic       triac_on;
        logic       led_on;
        logic       send_off_code;
        logic [6:0] level;
        logic       tripped;
        logic       halted;
        logic       ac_present;
        logic       checking;
    } t_result;

    // Register reset values
    localparam logic [6:0] BRIGHT_HIGH_RST      = 7'd85;
    localparam logic [6:0] BRIGHT_LOW_RST       = 7'd5;
    localparam logic [9:0] TEMP_CHECK_LEVEL_RST = 10'd340;
    localparam logic [9:0] TEMP_TRIP_LEVEL_RST  = 10'd280;
    localparam logic [4:0] TRIP_COUNT_RST       = 5'd20;
    localparam logic [5:0] CHECK_LIMIT_RST      = 6'd40;
    localparam logic [4:0] AC_TIMEOUT_RST       = 5'd20;
    localparam logic [8:0] SEND_GAP_RST         = 9'd400;

    // Counter limits
    localparam logic [6:0] LEVEL_MAX      = 7'd127;
    localparam logic [6:0] LED_OFF_COUNT  = 7'd100;
    localparam logic [6:0] LED_COUNT_MAX  = 7'd105;
    localparam logic [8:0] SEND_COUNT_MAX = 9'd500;
    localparam logic [4:0] AC_COUNT_MAX   = 5'd31;
    localparam logic [5:0] TRIP_CNT_MAX   = 6'd63;
    localparam logic [6:0] CHECK_ITER_MAX = 7'd127;

endpackage

// File: design/tpd_cfg.sv
module tpd_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output tpd_pkg::t_cfg                o_cfg
);

    tpd_pkg::t_cfg    r_cfg;
    tpd_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = tpd_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bright_high      <= tpd_pkg::BRIGHT_HIGH_RST;
            r_cfg.bright_low       <= tpd_pkg::BRIGHT_LOW_RST;
            r_cfg.temp_check_level <= tpd_pkg::TEMP_CHECK_LEVEL_RST;
            r_cfg.temp_trip_level  <= tpd_pkg::TEMP_TRIP_LEVEL_RST;
            r_cfg.trip_count       <= tpd_pkg::TRIP_COUNT_RST;
            r_cfg.check_limit      <= tpd_pkg::CHECK_LIMIT_RST;
            r_cfg.ac_timeout       <= tpd_pkg::AC_TIMEOUT_RST;
            r_cfg.send_gap         <= tpd_pkg::SEND_GAP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                tpd_pkg::REG_BRIGHT_HIGH:      r_cfg.bright_high      <= pwdata[6:0];
                tpd_pkg::REG_BRIGHT_LOW:       r_cfg.bright_low       <= pwdata[6:0];
                tpd_pkg::REG_TEMP_CHECK_LEVEL: r_cfg.temp_check_level <= pwdata[9:0];
                tpd_pkg::REG_TEMP_TRIP_LEVEL:  r_cfg.temp_trip_level  <= pwdata[9:0];
                tpd_pkg::REG_TRIP_COUNT:       r_cfg.trip_count       <= pwdata[4:0];
                tpd_pkg::REG_CHECK_LIMIT:      r_cfg.check_limit      <= pwdata[5:0];
                tpd_pkg::REG_AC_TIMEOUT:       r_cfg.ac_timeout       <= pwdata[4:0];
                tpd_pkg::REG_SEND_GAP:         r_cfg.send_gap         <= pwdata[8:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tpd_pkg::REG_BRIGHT_HIGH:      prdata = {25'd0, r_cfg.bright_high};
            tpd_pkg::REG_BRIGHT_LOW:       prdata = {25'd0, r_cfg.bright_low};
            tpd_pkg::REG_TEMP_CHECK_LEVEL: prdata = {22'd0, r_cfg.temp_check_level};
            tpd_pkg::REG_TEMP_TRIP_LEVEL:  prdata = {22'd0, r_cfg.temp_trip_level};
            tpd_pkg::REG_TRIP_COUNT:       prdata = {27'd0, r_cfg.trip_count};
            tpd_pkg::REG_CHECK_LIMIT:      prdata = {26'd0, r_cfg.check_limit};
            tpd_pkg::REG_AC_TIMEOUT:       prdata = {27'd0, r_cfg.ac_timeout};
            tpd_pkg::REG_SEND_GAP:         prdata = {23'd0, r_cfg.send_gap};
        endcase
    end

endmodule

// File: design/tpd_core.sv
module tpd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [1:0]        i_op,
    input  logic [9:0]        i_temp_a,
    input  logic [9:0]        i_temp_b,
    input  tpd_pkg::t_cfg     i_cfg,
    output tpd_pkg::t_result  o_result
);

    logic [6:0]                    r_ramp, n_ramp;
    logic                          r_ramp_up, n_ramp_up;
    logic [6:0]                    r_latched, n_latched;
    logic [tpd_pkg::PHASE_BITS-1:0] r_phase, n_phase;
    logic [4:0]                    r_ac, n_ac;
    logic [6:0]                    r_ledc, n_ledc;
    logic [8:0]                    r_send, n_send;
    logic [5:0]                    r_tc, n_tc;
    logic [6:0]                    r_ci, n_ci;
    logic                          r_trip, n_trip;
    logic                          r_check, n_check;
    logic                          r_halt, n_halt;
    logic                          r_gate, n_gate;
    logic                          r_led, n_led;

    logic                          send;
    logic                          finish;
    logic                          low_trip;
    logic                          low_check;
    logic [5:0]                    tc_up;
    logic [6:0]                    ci_up;
    logic [tpd_pkg::PHASE_BITS-1:0] ph_up;

    assign low_trip  = (i_temp_a < i_cfg.temp_trip_level) ||
                       (i_temp_b < i_cfg.temp_trip_level);
    assign low_check = (i_temp_a < i_cfg.temp_check_level) ||
                       (i_temp_b < i_cfg.temp_check_level);
    assign tc_up = (r_tc < tpd_pkg::TRIP_CNT_MAX)   ? r_tc + 6'd1 : r_tc;
    assign ci_up = (r_ci < tpd_pkg::CHECK_ITER_MAX) ? r_ci + 7'd1 : r_ci;
    assign ph_up = (r_phase < tpd_pkg::PHASE_MAX)
                 ? r_phase + tpd_pkg::PHASE_BITS'(1) : r_phase;

    always_comb begin
        n_ramp    = r_ramp;
        n_ramp_up = r_ramp_up;
        n_latched = r_latched;
        n_phase   = r_phase;
        n_ac      = r_ac;
        n_ledc    = r_ledc;
        n_send    = r_send;
        n_tc      = r_tc;
        n_ci      = r_ci;
        n_trip    = r_trip;
        n_check   = r_check;
        n_halt    = r_halt;
        n_gate    = r_gate;
        n_led     = r_led;
        send      = 1'b0;
        finish    = 1'b0;

        unique case (i_op)
            tpd_pkg::OP_ZERO_CROSS: begin
                if (!r_halt) begin
                    n_ac      = '0;
                    n_gate    = 1'b0;
                    n_latched = r_ramp;
                    n_phase   = '0;
                end
            end
            tpd_pkg::OP_PHASE_TICK: begin
                if (!r_halt) begin
                    n_phase = ph_up;
                    if (ph_up > tpd_pkg::PHASE_BITS'(r_latched)) begin
                        n_gate = 1'b1;
                    end
                end
            end
            tpd_pkg::OP_CONTROL_TICK: begin
                if (r_check) begin
                    // one check iteration
                    if (low_trip && (tc_up > {1'b0, i_cfg.trip_count})) begin
                        n_tc   = '0;
                        n_trip = 1'b1;
                        finish = 1'b1;
                    end else if (!low_trip && (r_tc == 6'd0)) begin
                        finish = 1'b1;
                    end else begin
                        n_tc = low_trip ? tc_up : r_tc - 6'd1;
                        if (ci_up > {1'b0, i_cfg.check_limit}) begin
                            n_ci   = '0;
                            finish = 1'b1;
                        end else begin
                            n_ci = ci_up;
                        end
                    end
                    if (finish) begin
                        n_check = 1'b0;
                    end
                end else if (r_ramp > i_cfg.bright_high) begin
                    n_ramp_up = 1'b0;
                    if (low_check) begin
                        n_check = 1'b1;
                    end else begin
                        finish = 1'b1;
                    end
                end else begin
                    if (r_ramp < i_cfg.bright_low) begin
                        n_ramp_up = 1'b1;
                    end
                    finish = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (finish) begin
            // ramp step, saturating at both ends
            if (n_ramp_up) begin
                if (r_ramp < tpd_pkg::LEVEL_MAX) n_ramp = r_ramp + 7'd1;
            end else begin
                if (r_ramp > 7'd0) n_ramp = r_ramp - 7'd1;
            end
            // power-down
            if (n_trip && (r_send > i_cfg.send_gap) && (r_ac <= i_cfg.ac_timeout)) begin
                n_gate = 1'b0;
                n_halt = 1'b1;
                send   = 1'b1;
                n_send = '0;
                n_led  = 1'b1;
                n_ledc = '0;
            end
            if (n_ledc == tpd_pkg::LED_OFF_COUNT) n_led = 1'b0;
            if (n_ledc < tpd_pkg::LED_COUNT_MAX)  n_ledc = n_ledc + 7'd1;
            if (n_send < tpd_pkg::SEND_COUNT_MAX) n_send = n_send + 9'd1;
            if (r_ac < tpd_pkg::AC_COUNT_MAX)     n_ac = r_ac + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp    <= '0;
            r_ramp_up <= 1'b1;
            r_latched <= '0;
            r_phase   <= '0;
            r_ac      <= '0;
            r_ledc    <= tpd_pkg::LED_COUNT_MAX;
            r_send    <= tpd_pkg::SEND_COUNT_MAX;
            r_tc      <= '0;
            r_ci      <= '0;
            r_trip    <= 1'b0;
            r_check   <= 1'b0;
            r_halt    <= 1'b0;
            r_gate    <= 1'b0;
            r_led     <= 1'b0;
        end else if (i_load) begin
            r_ramp    <= n_ramp;
            r_ramp_up <= n_ramp_up;
            r_latched <= n_latched;
            r_phase   <= n_phase;
            r_ac      <= n_ac;
            r_ledc    <= n_ledc;
            r_send    <= n_send;
            r_tc      <= n_tc;
            r_ci      <= n_ci;
            r_trip    <= n_trip;
            r_check   <= n_check;
            r_halt    <= n_halt;
            r_gate    <= n_gate;
            r_led     <= n_led;
        end
    end

    always_comb begin
        o_result.triac_on      = n_gate;
        o_result.led_on        = n_led;
        o_result.send_off_code = send;
        o_result.level         = n_ramp;
        o_result.tripped       = n_trip;
        o_result.halted        = n_halt;
        o_result.ac_present    = (n_ac <= i_cfg.ac_timeout);
        o_result.checking      = n_check;
    end

endmodule

// File: design/tpd_out.sv
module tpd_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tpd_pkg::t_result  i_result,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output tpd_pkg::t_result  o_result,
    output logic              o_space
);

    logic             r_valid;
    tpd_pkg::t_result r_result;

    // free when empty or when the held word leaves this cycle
    assign o_space     = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: design/triac_phase_dimmer_with_thermal_trip.sv
// Phase-angle triac dimmer with over-temperature trip.
// Input channel (i_in_valid / o_in_ready): one word per item, i_op selects a
//   zero-cross event, a phase timer tick or a control tick; i_temp_a and
//   i_temp_b carry the two temperature samples used by control ticks.
// Output channel (o_out_valid / i_out_ready): exactly one word per input word,
//   the gate, LED, level and status flags as they stand after that item, plus
//   the off-code request raised by a power-down.
// The state update is one short combinational pass from the state registers
//   into the result register. Throughput is one word per cycle while the
//   receiver takes words, set by that single register stage.
// When the receiver stalls, the result register holds its word and input is
//   taken again in the same cycle that word leaves, so a stall costs nothing
//   beyond its own length.
// Reset (i_rst_n low, synchronous) empties the output, restores the state and
//   configuration registers to their defaults and clears trip and halt latches.
// Registers sit at byte address 4*index on the APB port; write them only while
//   the block is idle.
module triac_phase_dimmer_with_thermal_trip (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_op,
    input  logic [9:0]                   i_temp_a,
    input  logic [9:0]                   i_temp_b,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_triac_on,
    output logic                         o_led_on,
    output logic                         o_send_off_code,
    output logic [6:0]                   o_level,
    output logic                         o_tripped,
    output logic                         o_halted,
    output logic                         o_ac_present,
    output logic                         o_checking,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tpd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    tpd_pkg::t_cfg    cfg;
    tpd_pkg::t_result core_result;
    tpd_pkg::t_result out_result;
    logic             space;
    logic             accept;

    // take a word whenever the result register can absorb its result
    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    tpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // state registers and the single-pass update
    tpd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_op     (i_op),
        .i_temp_a (i_temp_a),
        .i_temp_b (i_temp_b),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // result register parting the two channels
    tpd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (core_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (out_result),
        .o_space     (space)
    );

    assign o_triac_on      = out_result.triac_on;
    assign o_led_on        = out_result.led_on;
    assign o_send_off_code = out_result.send_off_code;
    assign o_level         = out_result.level;
    assign o_tripped       = out_result.tripped;
    assign o_halted        = out_result.halted;
    assign o_ac_present    = out_result.ac_present;
    assign o_checking      = out_result.checking;

endmodule

// File: design/tpd_checker.sv
`include "triac_phase_dimmer_with_thermal_trip_assert.svh"

module tpd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_triac_on,
    input logic o_led_on,
    input logic o_send_off_code,
    input logic o_tripped,
    input logic o_halted
);

    // a stalled word stays
    `TPD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // an accepted word shows up in the following cycle
    `TPD_ASSERT_NEXT(a_one_cycle, i_in_valid && o_in_ready, o_out_valid)

    // an off request only comes with the power-down it causes
    `TPD_ASSERT_NOW(a_send_pd, o_out_valid && o_send_off_code,
        o_halted && o_tripped && o_led_on && !o_triac_on)

    // a halted dimmer never drives the gate
    `TPD_ASSERT_NOW(a_halt_gate, o_out_valid && o_halted, !o_triac_on)

endmodule

bind triac_phase_dimmer_with_thermal_trip tpd_checker u_tpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_triac_on      (o_triac_on),
    .o_led_on        (o_led_on),
    .o_send_off_code (o_send_off_code),
    .o_tripped       (o_tripped),
    .o_halted        (o_halted)
);

// File: dv/dimmer_result_checker.sv
`timescale 1ns / 100ps

// Watches both word channels and the config port, runs a cycle-free model of
// the dimmer on every accepted input word and compares each output word.
module dimmer_result_checker
    import tpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_op,
    input  logic [9:0]           i_temp_a,
    input  logic [9:0]           i_temp_b,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_result              i_result,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic                 i_pready,
    input  logic [ADDR_BITS-1:0] i_paddr,
    input  logic [31:0]          i_pwdata,
    output int                   o_mismatches,
    output int                   o_pending
);

    t_cfg                  cfg;
    logic [6:0]            ramp_lvl;
    logic                  going_up;
    logic [6:0]            held_lvl;
    logic [PHASE_BITS-1:0] phase_cnt;
    logic [4:0]            ac_cnt;
    logic [6:0]            led_cnt;
    logic [8:0]            send_cnt;
    logic [5:0]            trip_cnt;
    logic [6:0]            iter_cnt;
    logic                  trip_q;
    logic                  check_q;
    logic                  halt_q;
    logic                  gate_q;
    logic                  led_q;

    t_result expected_words[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Ramp step, power-down and counter upkeep; returns the off-code pulse.
    function automatic logic close_control_tick();
        logic sent;
        sent = 1'b0;
        if (going_up) begin
            if (ramp_lvl < LEVEL_MAX) ramp_lvl++;
        end else if (ramp_lvl > 0) begin
            ramp_lvl--;
        end
        if (trip_q && send_cnt > cfg.send_gap && ac_cnt <= cfg.ac_timeout) begin
            gate_q   = 1'b0;
            halt_q   = 1'b1;
            sent     = 1'b1;
            send_cnt = '0;
            led_q    = 1'b1;
            led_cnt  = '0;
        end
        if (led_cnt == LED_OFF_COUNT) led_q = 1'b0;
        if (led_cnt < LED_COUNT_MAX) led_cnt++;
        if (send_cnt < SEND_COUNT_MAX) send_cnt++;
        if (ac_cnt < AC_COUNT_MAX) ac_cnt++;
        return sent;
    endfunction

    function automatic t_result advance_dimmer(logic [1:0] op, logic [9:0] a, logic [9:0] b);
        t_result res;
        logic    sent;
        logic    check_done;
        sent       = 1'b0;
        check_done = 1'b0;
        case (op)
            OP_ZERO_CROSS: begin
                if (!halt_q) begin
                    ac_cnt    = '0;
                    gate_q    = 1'b0;
                    held_lvl  = ramp_lvl;
                    phase_cnt = '0;
                end
            end
            OP_PHASE_TICK: begin
                if (!halt_q) begin
                    if (phase_cnt < PHASE_MAX) phase_cnt++;
                    if (phase_cnt > held_lvl) gate_q = 1'b1;
                end
            end
            OP_CONTROL_TICK: begin
                if (check_q) begin
                    // one check iteration per control tick
                    if (a < cfg.temp_trip_level || b < cfg.temp_trip_level) begin
                        if (trip_cnt < TRIP_CNT_MAX) trip_cnt++;
                        if (trip_cnt > cfg.trip_count) begin
                            trip_cnt   = '0;
                            trip_q     = 1'b1;
                            check_done = 1'b1;
                        end
                    end else if (trip_cnt == 0) begin
                        check_done = 1'b1;
                    end else begin
                        trip_cnt--;
                    end
                    if (!check_done) begin
                        if (iter_cnt < CHECK_ITER_MAX) iter_cnt++;
                        if (iter_cnt > cfg.check_limit) begin
                            iter_cnt   = '0;
                            check_done = 1'b1;
                        end
                    end
                    if (check_done) begin
                        check_q = 1'b0;
                        sent    = close_control_tick();
                    end
                end else if (ramp_lvl > cfg.bright_high) begin
                    going_up = 1'b0;
                    if (a < cfg.temp_check_level || b < cfg.temp_check_level)
                        check_q = 1'b1;
                    else
                        sent = close_control_tick();
                end else begin
                    if (ramp_lvl < cfg.bright_low) going_up = 1'b1;
                    sent = close_control_tick();
                end
            end
            default: ;
        endcase
        res.triac_on      = gate_q;
        res.led_on        = led_q;
        res.send_off_code = sent;
        res.level         = ramp_lvl;
        res.tripped       = trip_q;
        res.halted        = halt_q;
        res.ac_present    = (ac_cnt <= cfg.ac_timeout);
        res.checking      = check_q;
        return res;
    endfunction

    always @(posedge i_clk) begin : track_words
        t_result want;
        logic    bad;
        if (!i_rst_n) begin
            cfg.bright_high      = BRIGHT_HIGH_RST;
            cfg.bright_low       = BRIGHT_LOW_RST;
            cfg.temp_check_level = TEMP_CHECK_LEVEL_RST;
            cfg.temp_trip_level  = TEMP_TRIP_LEVEL_RST;
            cfg.trip_count       = TRIP_COUNT_RST;
            cfg.check_limit      = CHECK_LIMIT_RST;
            cfg.ac_timeout       = AC_TIMEOUT_RST;
            cfg.send_gap         = SEND_GAP_RST;
            ramp_lvl  = '0;
            going_up  = 1'b1;
            held_lvl  = '0;
            phase_cnt = '0;
            ac_cnt    = '0;
            led_cnt   = LED_COUNT_MAX;
            send_cnt  = SEND_COUNT_MAX;
            trip_cnt  = '0;
            iter_cnt  = '0;
            trip_q    = 1'b0;
            check_q   = 1'b0;
            halt_q    = 1'b0;
            gate_q    = 1'b0;
            led_q     = 1'b0;
            expected_words.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[ADDR_BITS-1:2]))
                    REG_BRIGHT_HIGH:      cfg.bright_high      = i_pwdata[6:0];
                    REG_BRIGHT_LOW:       cfg.bright_low       = i_pwdata[6:0];
                    REG_TEMP_CHECK_LEVEL: cfg.temp_check_level = i_pwdata[9:0];
                    REG_TEMP_TRIP_LEVEL:  cfg.temp_trip_level  = i_pwdata[9:0];
                    REG_TRIP_COUNT:       cfg.trip_count       = i_pwdata[4:0];
                    REG_CHECK_LIMIT:      cfg.check_limit      = i_pwdata[5:0];
                    REG_AC_TIMEOUT:       cfg.ac_timeout       = i_pwdata[4:0];
                    REG_SEND_GAP:         cfg.send_gap         = i_pwdata[8:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(advance_dimmer(i_op, i_temp_a, i_temp_b));
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: output word with none expected", $time);
                end else begin
                    want = expected_words.pop_front();
                    bad  = (i_result.triac_on !== want.triac_on)
                         | (i_result.led_on !== want.led_on)
                         | (i_result.send_off_code !== want.send_off_code)
                         | (i_result.level !== want.level)
                         | (i_result.tripped !== want.tripped)
                         | (i_result.halted !== want.halted)
                         | (i_result.ac_present !== want.ac_present)
                         | (i_result.checking !== want.checking);
                    if (bad) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display("%0t: mismatch expected gate=%b led=%b send=%b level=%0d",
                                     $time, want.triac_on, want.led_on, want.send_off_code,
                                     want.level);
                            $display("    trip=%b halt=%b ac=%b check=%b",
                                     want.tripped, want.halted, want.ac_present,
                                     want.checking);
                            $display("  actual gate=%b led=%b send=%b level=%0d",
                                     i_result.triac_on, i_result.led_on,
                                     i_result.send_off_code, i_result.level);
                            $display("    trip=%b halt=%b ac=%b check=%b",
                                     i_result.tripped, i_result.halted,
                                     i_result.ac_present, i_result.checking);
                        end
                    end
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// File: dv/tb_triac_phase_dimmer_with_thermal_trip.sv
`timescale 1ns / 100ps

// Top of the dimmer bench: clock, reset, stimulus and the verdict. Checking
// itself lives in dimmer_result_checker, which sits beside the block.
module tb_triac_phase_dimmer_with_thermal_trip;
    import tpd_pkg::*;

    // Op code the block must treat as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Cycles without any accepted word before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           op_sel;
    logic [9:0]           temp_a;
    logic [9:0]           temp_b;
    logic                 out_valid;
    logic                 out_ready;
    logic                 triac_on;
    logic                 led_on;
    logic                 send_off_code;
    logic [6:0]           level;
    logic                 tripped;
    logic                 halted;
    logic                 ac_present;
    logic                 checking;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    int mismatches;
    int pending;

    // Shared idle switch for both sides; quiet_tail pins it off for the end.
    logic idling;
    logic quiet_tail;
    // Current thresholds, kept here to aim temperature samples at them.
    int   trip_lvl;
    int   check_lvl;

    triac_phase_dimmer_with_thermal_trip uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_op            (op_sel),
        .i_temp_a        (temp_a),
        .i_temp_b        (temp_b),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_triac_on      (triac_on),
        .o_led_on        (led_on),
        .o_send_off_code (send_off_code),
        .o_level         (level),
        .o_tripped       (tripped),
        .o_halted        (halted),
        .o_ac_present    (ac_present),
        .o_checking      (checking),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    dimmer_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_op         (op_sel),
        .i_temp_a     (temp_a),
        .i_temp_b     (temp_b),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_result     ({triac_on, led_on, send_off_code, level,
                        tripped, halted, ac_present, checking}),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: stall in bursts of random length while idling is on,
    // otherwise take every word as soon as it shows up.
    initial begin : receiver
        int hold;
        out_ready = 1'b1;
        forever begin
            @(negedge clk);
            if (idling && $urandom_range(5, 0) == 0) begin
                hold = $urandom_range(9, 1);
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Hang detector: count cycles where neither channel moves a word.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one input word. Entered and left at a falling edge; valid stays
    // high on return so back-to-back words need no bubble.
    task automatic send_word(input logic [1:0] op, input logic [9:0] a, input logic [9:0] b);
        int gap;
        if (idling && $urandom_range(5, 0) == 0) begin
            gap = $urandom_range(9, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op_sel   <= op;
        temp_a   <= a;
        temp_b   <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // APB write: setup cycle, access cycle, then release the bus so the next
    // write starts on a fresh edge.
    task automatic write_reg(input t_reg_idx idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Drain the block completely, then load a full register set. This is
    // also where the sender holds off until every result has come back.
    task automatic apply_settings(input int bh, input int bl, input int chk, input int trp,
                                  input int tcnt, input int clim, input int act,
                                  input int gap);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
        write_reg(REG_BRIGHT_HIGH, bh);
        write_reg(REG_BRIGHT_LOW, bl);
        write_reg(REG_TEMP_CHECK_LEVEL, chk);
        write_reg(REG_TEMP_TRIP_LEVEL, trp);
        write_reg(REG_TRIP_COUNT, tcnt);
        write_reg(REG_CHECK_LIMIT, clim);
        write_reg(REG_AC_TIMEOUT, act);
        write_reg(REG_SEND_GAP, gap);
        trip_lvl  = trp;
        check_lvl = chk;
    endtask

    // Temperature sample: rails now and then, otherwise aimed below the trip
    // level with weight low_pct, then between the levels, else above both.
    function automatic logic [9:0] pick_temp(input int low_pct);
        int r;
        r = $urandom_range(99, 0);
        if (r < 8)
            return ($urandom_range(1, 0) != 0) ? 10'h3FF : 10'h000;
        if (r < 8 + low_pct && trip_lvl > 0)
            return 10'($urandom_range(trip_lvl - 1, 0));
        if (r < 23 + low_pct && check_lvl > trip_lvl)
            return 10'($urandom_range(check_lvl - 1, trip_lvl));
        return 10'($urandom_range(1023, check_lvl));
    endfunction

    // Mains-like traffic: each half cycle opens with a zero-cross (dropped
    // now and then to let AC time out), followed by a run of phase ticks
    // with control ticks mixed in. A long run is pure phase ticks to push the
    // phase count into saturation. Stray crossings and the unused op code
    // are sprinkled in as noise.
    task automatic run_mains(input int n_items, input int ctrl_pct, input int max_len,
                             input int long_pct, input int low_pct);
        int         sent_words;
        int         len;
        int         r;
        logic       long_run;
        logic [1:0] pick;
        sent_words = 0;
        while (sent_words < n_items) begin
            if (!quiet_tail && $urandom_range(7, 0) == 0) idling = !idling;
            if ($urandom_range(9, 0) != 0) begin
                send_word(OP_ZERO_CROSS, pick_temp(low_pct), pick_temp(low_pct));
                sent_words++;
            end
            long_run = ($urandom_range(99, 0) < long_pct);
            len = long_run ? $urandom_range(270, 256) : $urandom_range(max_len, 1);
            for (int k = 0; k < len && sent_words < n_items; k++) begin
                r = $urandom_range(99, 0);
                if (long_run)
                    pick = OP_PHASE_TICK;
                else if (r < 2)
                    pick = OP_UNUSED;
                else if (r < 5)
                    pick = OP_ZERO_CROSS;
                else if (r < 5 + ctrl_pct)
                    pick = OP_CONTROL_TICK;
                else
                    pick = OP_PHASE_TICK;
                send_word(pick, pick_temp(low_pct), pick_temp(low_pct));
                sent_words++;
            end
        end
    endtask

    initial begin : stimulus
        in_valid   = 1'b0;
        op_sel     = OP_ZERO_CROSS;
        temp_a     = '0;
        temp_b     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idling     = 1'b0;
        quiet_tail = 1'b0;
        trip_lvl   = TEMP_TRIP_LEVEL_RST;
        check_lvl  = TEMP_CHECK_LEVEL_RST;

        // Hold reset low, then release it on a falling edge.
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening at reset settings: gate firing right after a
        // crossing, sample rails and threshold edges, the unused op code.
        send_word(OP_ZERO_CROSS, 10'h000, 10'h000);
        send_word(OP_PHASE_TICK, 10'h3FF, 10'h3FF);
        send_word(OP_PHASE_TICK, 10'h000, 10'h3FF);
        send_word(OP_CONTROL_TICK, 10'h3FF, 10'h3FF);
        send_word(OP_CONTROL_TICK, 10'h000, 10'h3FF);
        send_word(OP_CONTROL_TICK, 10'h3FF, 10'h000);
        send_word(OP_UNUSED, 10'h2AA, 10'h155);
        // Latch level 3, then the gate must wait for the fourth tick.
        send_word(OP_ZERO_CROSS, 10'h155, 10'h2AA);
        repeat (4) send_word(OP_PHASE_TICK, 10'h000, 10'h000);
        send_word(OP_CONTROL_TICK, 10'd339, 10'd340);
        send_word(OP_CONTROL_TICK, 10'd279, 10'd280);
        send_word(OP_CONTROL_TICK, 10'd341, 10'd281);
        send_word(OP_UNUSED, 10'h3FF, 10'h3FF);
        send_word(OP_ZERO_CROSS, 10'h3FF, 10'h000);
        send_word(OP_PHASE_TICK, 10'h000, 10'h000);
        send_word(OP_CONTROL_TICK, 10'h000, 10'h000);
        send_word(OP_UNUSED, 10'h000, 10'h000);

        // Narrow ramp, checks that cannot trip, short check limit.
        apply_settings(8, 2, 600, 200, 31, 6, 5, 499);
        run_mains(350, 40, 12, 0, 10);

        // Widest legal ramp, wide timeouts, zero send gap; long phase runs.
        apply_settings(126, 0, 1023, 0, 31, 63, 30, 0);
        run_mains(300, 60, 10, 10, 10);

        // Out-of-range ramp limits, counts of one, AC flapping.
        apply_settings(0, 127, 1023, 0, 1, 1, 1, 511);
        run_mains(200, 50, 6, 0, 10);

        // Trip run: low readings, quick trip, AC mostly present, so the halt,
        // the off-code pulse and the full LED timeout all happen here.
        apply_settings(3, 1, 700, 500, 2, 63, 3, 10);
        run_mains(400, 50, 3, 0, 70);

        // Tail without idling: AC never times out, send gap zero, so a
        // latched trip keeps re-issuing the off code.
        quiet_tail = 1'b1;
        idling     = 1'b0;
        apply_settings(127, 0, 0, 1023, 1, 1, 31, 0);
        run_mains(250, 60, 8, 0, 50);

        // Drop valid, drain what is still in flight, keep watching for any
        // unexpected word, then judge.
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/tpd_pkg.sv
design/tpd_cfg.sv
design/tpd_core.sv
design/tpd_out.sv
design/triac_phase_dimmer_with_thermal_trip.sv
design/tpd_checker.sv
dv/dimmer_result_checker.sv
dv/tb_triac_phase_dimmer_with_thermal_trip.sv
